// ----- src/arbc_pkg.sv -----
// shared constants, types, saturation helpers and exponential table for the rbf controller
package arbc_pkg;

    localparam int N_BASIS         = 16;
    localparam int EXP_TABLE_DEPTH = 1024;
    localparam int AW              = $clog2(EXP_TABLE_DEPTH);
    localparam int IW              = $clog2(N_BASIS);
    localparam int DIV_STEPS       = 56;
    localparam int DCW             = $clog2(DIV_STEPS);
    localparam int OPW             = 6;

    localparam logic signed [31:0] WEIGHT_INIT = 32'sd655;

    // configuration register indexes
    localparam logic [7:0] CFG_GAIN_FIRST     = 8'd0;
    localparam logic [7:0] CFG_GAIN_SECOND    = 8'd1;
    localparam logic [7:0] CFG_ADAPT_RATE     = 8'd2;
    localparam logic [7:0] CFG_ROBUST_GAIN    = 8'd3;
    localparam logic [7:0] CFG_LEAKAGE        = 8'd4;
    localparam logic [7:0] CFG_TIME_STEP      = 8'd5;
    localparam logic [7:0] CFG_CENTER_FIRST   = 8'd6;
    localparam logic [7:0] CFG_CENTER_SPACING = 8'd7;

    // sequencer steps; each is also the datapath operation of that cycle
    localparam logic [OPW-1:0] OP_IDLE   = 6'd0;
    localparam logic [OPW-1:0] OP_LOAD   = 6'd1;
    localparam logic [OPW-1:0] OP_DIFF   = 6'd2;
    localparam logic [OPW-1:0] OP_DIV1S  = 6'd3;
    localparam logic [OPW-1:0] OP_DSTEP  = 6'd4;
    localparam logic [OPW-1:0] OP_RATIO  = 6'd5;
    localparam logic [OPW-1:0] OP_M_RR   = 6'd6;
    localparam logic [OPW-1:0] OP_IDX    = 6'd7;
    localparam logic [OPW-1:0] OP_ROMRD  = 6'd8;
    localparam logic [OPW-1:0] OP_PHI    = 6'd9;
    localparam logic [OPW-1:0] OP_M_RP   = 6'd10;
    localparam logic [OPW-1:0] OP_DIV2S  = 6'd11;
    localparam logic [OPW-1:0] OP_DPHI   = 6'd12;
    localparam logic [OPW-1:0] OP_ZERO   = 6'd13;
    localparam logic [OPW-1:0] OP_M_WP   = 6'd14;
    localparam logic [OPW-1:0] OP_ACCF   = 6'd15;
    localparam logic [OPW-1:0] OP_M_WD   = 6'd16;
    localparam logic [OPW-1:0] OP_ACCD   = 6'd17;
    localparam logic [OPW-1:0] OP_M_PP   = 6'd18;
    localparam logic [OPW-1:0] OP_ACCN   = 6'd19;
    localparam logic [OPW-1:0] OP_SC1    = 6'd20;
    localparam logic [OPW-1:0] OP_M_K1Z1 = 6'd21;
    localparam logic [OPW-1:0] OP_ALPHA  = 6'd22;
    localparam logic [OPW-1:0] OP_Z2     = 6'd23;
    localparam logic [OPW-1:0] OP_M_Z2D  = 6'd24;
    localparam logic [OPW-1:0] OP_TAU    = 6'd25;
    localparam logic [OPW-1:0] OP_M_K2Z2 = 6'd26;
    localparam logic [OPW-1:0] OP_USUB1  = 6'd27;
    localparam logic [OPW-1:0] OP_M_DXF  = 6'd28;
    localparam logic [OPW-1:0] OP_UADD1  = 6'd29;
    localparam logic [OPW-1:0] OP_M_K1R  = 6'd30;
    localparam logic [OPW-1:0] OP_UADD2  = 6'd31;
    localparam logic [OPW-1:0] OP_M_KWZ2 = 6'd32;
    localparam logic [OPW-1:0] OP_TMP1   = 6'd33;
    localparam logic [OPW-1:0] OP_M_TPN  = 6'd34;
    localparam logic [OPW-1:0] OP_USUB2  = 6'd35;
    localparam logic [OPW-1:0] OP_M_GT   = 6'd36;
    localparam logic [OPW-1:0] OP_GT     = 6'd37;
    localparam logic [OPW-1:0] OP_M_GP   = 6'd38;
    localparam logic [OPW-1:0] OP_TMP2   = 6'd39;
    localparam logic [OPW-1:0] OP_M_SW   = 6'd40;
    localparam logic [OPW-1:0] OP_INC    = 6'd41;
    localparam logic [OPW-1:0] OP_M_DT   = 6'd42;
    localparam logic [OPW-1:0] OP_WUPD   = 6'd43;
    localparam logic [OPW-1:0] OP_DONE   = 6'd44;

    typedef struct packed {
        logic [OPW-1:0] op;
        logic [IW-1:0]  idx;
    } cmd_t;

    typedef struct packed {
        logic near;
        logic idx_ok;
        logic out_free;
    } status_t;

    typedef logic [16:0] exp_rom_t [EXP_TABLE_DEPTH];

    localparam logic signed [63:0] S32_MAX_W = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN_W = -64'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > S32_MAX_W) return 32'sh7FFF_FFFF;
        else if (v < S32_MIN_W) return 32'sh8000_0000;
        else return v[31:0];
    endfunction

    function automatic logic ovf32(input logic signed [63:0] v);
        return (v > S32_MAX_W) || (v < S32_MIN_W);
    endfunction

    // exp(-t) over [0,16) from a q30 recurrence on a taylor sum of one step
    function automatic exp_rom_t build_exp_rom();
        exp_rom_t          t;
        logic [63:0]       xq;
        logic [63:0]       term;
        logic [63:0]       q;
        logic signed [63:0] sum;
        xq   = (64'd16 << 30) / 64'(EXP_TABLE_DEPTH);
        term = 64'd1 << 30;
        sum  = $signed(term);
        q    = 64'd1 << 30;
        for (int n = 1; n <= 14; n++) begin
            term = ((term * xq) >> 30) / 64'(n);
            if (n % 2 == 1) sum = sum - $signed(term);
            else sum = sum + $signed(term);
        end
        if (sum < 0) sum = 64'sd0;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            t[k] = 17'((q + 64'd8192) >> 14);
            q    = (q * $unsigned(sum) + (64'd1 << 29)) >> 30;
        end
        return t;
    endfunction

endpackage

// ----- src/arbc_exp_rom.sv -----
// exponential lookup table with registered read
module arbc_exp_rom (
    input  logic                 aclk,
    input  logic [arbc_pkg::AW-1:0] addr,
    output logic [16:0]          data
);
    import arbc_pkg::*;

    localparam exp_rom_t EXP_ROM = build_exp_rom();

    logic [16:0] data_reg;

    always_ff @(posedge aclk) begin
        data_reg <= EXP_ROM[addr];
    end

    assign data = data_reg;
endmodule

// ----- src/arbc_ctrl.sv -----
// sequencer: basis evaluation, control law, weight update; step per unstalled cycle
module arbc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  arbc_pkg::status_t status,
    output arbc_pkg::cmd_t    cmd
);
    import arbc_pkg::*;

    logic [OPW-1:0] state_reg, state_next;
    logic [IW-1:0]  i_reg, i_next;
    logic [DCW-1:0] dcnt_reg, dcnt_next;
    logic           div2_reg, div2_next;
    logic           last_basis;

    assign last_basis = (i_reg == IW'(N_BASIS - 1));
    assign s_tready   = (state_reg == OP_IDLE);

    always_comb begin
        cmd.idx = i_reg;
        if (state_reg == OP_IDLE) cmd.op = s_tvalid ? OP_LOAD : OP_IDLE;
        else cmd.op = state_reg;
    end

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        dcnt_next  = dcnt_reg;
        div2_next  = div2_reg;
        unique case (state_reg)
            OP_IDLE: begin
                if (s_tvalid) begin
                    state_next = OP_DIFF;
                    i_next     = '0;
                end
            end
            OP_DIFF:  state_next = OP_DIV1S;
            OP_DIV1S: begin
                dcnt_next = '0;
                div2_next = 1'b0;
                state_next = status.near ? OP_DSTEP : OP_ZERO;
            end
            OP_DSTEP: begin
                if (dcnt_reg == DCW'(DIV_STEPS - 1)) begin
                    state_next = div2_reg ? OP_DPHI : OP_RATIO;
                end else begin
                    dcnt_next = dcnt_reg + 1'b1;
                end
            end
            OP_RATIO: state_next = OP_M_RR;
            OP_M_RR:  state_next = OP_IDX;
            OP_IDX:   state_next = OP_ROMRD;
            OP_ROMRD: state_next = status.idx_ok ? OP_PHI : OP_ZERO;
            OP_PHI:   state_next = OP_M_RP;
            OP_M_RP:  state_next = OP_DIV2S;
            OP_DIV2S: begin
                dcnt_next  = '0;
                div2_next  = 1'b1;
                state_next = OP_DSTEP;
            end
            OP_DPHI:  state_next = OP_M_WP;
            OP_ZERO:  state_next = OP_M_WP;
            OP_M_WP:  state_next = OP_ACCF;
            OP_ACCF:  state_next = OP_M_WD;
            OP_M_WD:  state_next = OP_ACCD;
            OP_ACCD:  state_next = OP_M_PP;
            OP_M_PP:  state_next = OP_ACCN;
            OP_ACCN: begin
                if (last_basis) begin
                    state_next = OP_SC1;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = OP_DIFF;
                end
            end
            OP_SC1:    state_next = OP_M_K1Z1;
            OP_M_K1Z1: state_next = OP_ALPHA;
            OP_ALPHA:  state_next = OP_Z2;
            OP_Z2:     state_next = OP_M_Z2D;
            OP_M_Z2D:  state_next = OP_TAU;
            OP_TAU:    state_next = OP_M_K2Z2;
            OP_M_K2Z2: state_next = OP_USUB1;
            OP_USUB1:  state_next = OP_M_DXF;
            OP_M_DXF:  state_next = OP_UADD1;
            OP_UADD1:  state_next = OP_M_K1R;
            OP_M_K1R:  state_next = OP_UADD2;
            OP_UADD2:  state_next = OP_M_KWZ2;
            OP_M_KWZ2: state_next = OP_TMP1;
            OP_TMP1:   state_next = OP_M_TPN;
            OP_M_TPN:  state_next = OP_USUB2;
            OP_USUB2:  state_next = OP_M_GT;
            OP_M_GT:   state_next = OP_GT;
            OP_GT: begin
                i_next     = '0;
                state_next = OP_M_GP;
            end
            OP_M_GP:  state_next = OP_TMP2;
            OP_TMP2:  state_next = OP_M_SW;
            OP_M_SW:  state_next = OP_INC;
            OP_INC:   state_next = OP_M_DT;
            OP_M_DT:  state_next = OP_WUPD;
            OP_WUPD: begin
                if (last_basis) begin
                    state_next = OP_DONE;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = OP_M_GP;
                end
            end
            OP_DONE: begin
                if (status.out_free) state_next = OP_IDLE;
            end
            default: state_next = OP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= OP_IDLE;
            i_reg     <= '0;
            dcnt_reg  <= '0;
            div2_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            dcnt_reg  <= dcnt_next;
            div2_reg  <= div2_next;
        end
    end
endmodule

// ----- src/arbc_datapath.sv -----
// datapath: config registers, weights, shared multiplier, shift-subtract divider, output word
module arbc_datapath (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  arbc_pkg::cmd_t          cmd,
    output arbc_pkg::status_t       status,
    input  logic [159:0]            s_tdata,
    input  logic                    cfg_valid,
    input  logic [7:0]              cfg_index,
    input  logic [31:0]             cfg_data,
    output logic [arbc_pkg::AW-1:0] rom_addr,
    input  logic [16:0]             rom_data,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [31:0]             m_tdata,
    output logic                    m_tuser
);
    import arbc_pkg::*;

    // configuration
    logic [30:0]        k1_reg, k2_reg, gam_reg, kw_reg, sig_reg, dt_reg, sp_reg;
    logic signed [31:0] cf_reg;
    logic signed [31:0] w_reg [N_BASIS];

    // item inputs
    logic signed [31:0] x1_reg, x2_reg, yr_reg, dyr_reg, ddyr_reg;
    logic [30:0]        s_eff_reg;
    logic signed [39:0] centre_reg;

    // basis evaluation
    logic [34:0]        ad_reg;
    logic               dpos_reg, near_reg;
    logic [55:0]        num_reg;
    logic [34:0]        rem_reg;
    logic [33:0]        den_reg;
    logic [19:0]        r_reg;
    logic [AW-1:0]      idx_reg;
    logic               idx_ok_reg;
    logic [16:0]        phi_cur_reg;
    logic signed [31:0] dphi_cur_reg;
    logic [16:0]        phi_reg [N_BASIS];

    // multiplier
    logic [63:0]        mag_reg;
    logic               neg_reg;

    // sums and control law
    logic signed [55:0] fsum_reg, dsum_reg, nsum_reg;
    logic signed [31:0] fhat_reg, dwp_reg, pn2_reg, z1_reg, alpha_reg, dadx_reg;
    logic signed [31:0] z2_reg, xf_reg, tau_reg, tmp_reg, gt_reg, udrv_reg;
    logic signed [35:0] u_reg;
    logic               clip_reg;

    // output word
    logic               m_valid_reg;
    logic signed [31:0] drive_reg;
    logic               sat_reg;

    logic signed [39:0] diff;
    logic [39:0]        ad_full, reach;
    logic signed [48:0] pw;
    logic signed [31:0] qm;
    logic signed [31:0] mul_a, mul_b;
    logic [31:0]        ua, ub;
    logic               is_mul;
    logic signed [31:0] w_cur;
    logic [34:0]        rem_sh;
    logic               ge;
    logic [21:0]        e_val;
    logic [35:0]        idx_prod;
    logic [15:0]        idx_full;
    logic [36:0]        m_q;
    logic signed [37:0] m_neg;
    logic signed [31:0] dphi_val;
    logic               out_free;
    logic signed [31:0] k1s, k2s, gams, kws, sigs, dts;

    assign k1s  = $signed({1'b0, k1_reg});
    assign k2s  = $signed({1'b0, k2_reg});
    assign gams = $signed({1'b0, gam_reg});
    assign kws  = $signed({1'b0, kw_reg});
    assign sigs = $signed({1'b0, sig_reg});
    assign dts  = $signed({1'b0, dt_reg});

    assign w_cur   = w_reg[cmd.idx];
    assign diff    = 40'(x1_reg) - centre_reg;
    assign ad_full = diff[39] ? $unsigned(-diff) : $unsigned(diff);
    assign reach   = 40'(s_eff_reg) * 40'd12;

    // truncated q16 product, sign applied to the magnitude
    assign pw = neg_reg ? -$signed({1'b0, mag_reg[63:16]}) : $signed({1'b0, mag_reg[63:16]});
    assign qm = sat32(64'(pw));

    always_comb begin
        is_mul = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (cmd.op)
            OP_M_RR: begin
                mul_a = $signed({12'b0, r_reg});
                mul_b = $signed({12'b0, r_reg});
            end
            OP_M_RP: begin
                mul_a = $signed({12'b0, r_reg});
                mul_b = $signed({15'b0, phi_cur_reg});
            end
            OP_M_WP: begin
                mul_a = w_cur;
                mul_b = $signed({15'b0, phi_cur_reg});
            end
            OP_M_WD: begin
                mul_a = w_cur;
                mul_b = dphi_cur_reg;
            end
            OP_M_PP: begin
                mul_a = $signed({15'b0, phi_cur_reg});
                mul_b = $signed({15'b0, phi_cur_reg});
            end
            OP_M_K1Z1: begin mul_a = k1s;      mul_b = z1_reg;   end
            OP_M_Z2D:  begin mul_a = z2_reg;   mul_b = dadx_reg; end
            OP_M_K2Z2: begin mul_a = k2s;      mul_b = z2_reg;   end
            OP_M_DXF:  begin mul_a = dadx_reg; mul_b = xf_reg;   end
            OP_M_K1R:  begin mul_a = k1s;      mul_b = dyr_reg;  end
            OP_M_KWZ2: begin mul_a = kws;      mul_b = z2_reg;   end
            OP_M_TPN:  begin mul_a = tmp_reg;  mul_b = pn2_reg;  end
            OP_M_GT:   begin mul_a = gams;     mul_b = tau_reg;  end
            OP_M_GP: begin
                mul_a = gt_reg;
                mul_b = $signed({15'b0, phi_reg[cmd.idx]});
            end
            OP_M_SW:   begin mul_a = sigs;     mul_b = w_cur;    end
            OP_M_DT:   begin mul_a = dts;      mul_b = tmp_reg;  end
            default:   is_mul = 1'b0;
        endcase
    end

    assign ua = mul_a[31] ? $unsigned(-mul_a) : $unsigned(mul_a);
    assign ub = mul_b[31] ? $unsigned(-mul_b) : $unsigned(mul_b);

    // one restoring division step per cycle, quotient shifts into num_reg
    assign rem_sh = {rem_reg[33:0], num_reg[55]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    // table index: ratio squared over eight, rounded to the table grid
    assign e_val    = mag_reg[40:19];
    assign idx_prod = 36'(e_val) * 36'(EXP_TABLE_DEPTH) + (36'd1 << 19);
    assign idx_full = idx_prod[35:20];

    assign m_q   = num_reg[36:0];
    assign m_neg = 38'sd0 - $signed({1'b0, m_q});

    always_comb begin
        if (dpos_reg) begin
            dphi_val = (m_q > 37'h0_8000_0000) ? 32'sh8000_0000 : m_neg[31:0];
        end else begin
            dphi_val = (m_q > 37'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m_q[31:0]);
        end
    end

    assign out_free        = !m_valid_reg || m_tready;
    assign status.near     = near_reg;
    assign status.idx_ok   = idx_ok_reg;
    assign status.out_free = out_free;
    assign rom_addr        = idx_reg;

    // configuration, weights and output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k1_reg      <= 31'd65536;
            k2_reg      <= 31'd65536;
            gam_reg     <= 31'd65536;
            kw_reg      <= 31'd327680;
            sig_reg     <= 31'd6554;
            dt_reg      <= 31'd66;
            cf_reg      <= -32'sd131072;
            sp_reg      <= 31'd16384;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < N_BASIS; k++) w_reg[k] <= WEIGHT_INIT;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_GAIN_FIRST:     k1_reg  <= cfg_data[30:0];
                    CFG_GAIN_SECOND:    k2_reg  <= cfg_data[30:0];
                    CFG_ADAPT_RATE:     gam_reg <= cfg_data[30:0];
                    CFG_ROBUST_GAIN:    kw_reg  <= cfg_data[30:0];
                    CFG_LEAKAGE:        sig_reg <= cfg_data[30:0];
                    CFG_TIME_STEP:      dt_reg  <= cfg_data[30:0];
                    CFG_CENTER_FIRST:   cf_reg  <= $signed(cfg_data);
                    CFG_CENTER_SPACING: sp_reg  <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (cmd.op == OP_WUPD) w_reg[cmd.idx] <= sat32(64'(w_cur) + 64'(qm));
            if (cmd.op == OP_DONE && out_free) begin
                m_valid_reg <= 1'b1;
                drive_reg   <= udrv_reg;
                sat_reg     <= clip_reg;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (is_mul) begin
            mag_reg <= 64'(ua) * 64'(ub);
            neg_reg <= mul_a[31] ^ mul_b[31];
        end
        case (cmd.op) inside
            OP_LOAD: begin
                x1_reg     <= $signed(s_tdata[31:0]);
                x2_reg     <= $signed(s_tdata[63:32]);
                yr_reg     <= $signed(s_tdata[95:64]);
                dyr_reg    <= $signed(s_tdata[127:96]);
                ddyr_reg   <= $signed(s_tdata[159:128]);
                // zero spacing acts as one lsb
                s_eff_reg  <= (sp_reg == '0) ? 31'd1 : sp_reg;
                centre_reg <= 40'(cf_reg);
                fsum_reg   <= '0;
                dsum_reg   <= '0;
                nsum_reg   <= '0;
                clip_reg   <= 1'b0;
            end
            OP_DIFF: begin
                ad_reg     <= ad_full[34:0];
                dpos_reg   <= (diff > 40'sd0);
                near_reg   <= (ad_full < reach);
                centre_reg <= centre_reg + 40'(s_eff_reg);
            end
            OP_DIV1S: begin
                num_reg <= {5'b0, ad_reg, 16'b0};
                rem_reg <= '0;
                den_reg <= 34'(s_eff_reg);
            end
            OP_DIV2S: begin
                num_reg <= mag_reg[55:0];
                rem_reg <= '0;
                den_reg <= {1'b0, s_eff_reg, 2'b00};
            end
            OP_DSTEP: begin
                rem_reg <= ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
                num_reg <= {num_reg[54:0], ge};
            end
            OP_RATIO: r_reg <= num_reg[19:0];
            OP_IDX: begin
                idx_reg    <= idx_full[AW-1:0];
                idx_ok_reg <= (idx_full < 16'(EXP_TABLE_DEPTH));
            end
            OP_PHI: begin
                phi_cur_reg      <= rom_data;
                phi_reg[cmd.idx] <= rom_data;
            end
            OP_DPHI: dphi_cur_reg <= dphi_val;
            OP_ZERO: begin
                phi_cur_reg      <= '0;
                dphi_cur_reg     <= '0;
                phi_reg[cmd.idx] <= '0;
            end
            OP_ACCF: fsum_reg <= fsum_reg + 56'(pw);
            OP_ACCD: dsum_reg <= dsum_reg + 56'(pw);
            OP_ACCN: nsum_reg <= nsum_reg + 56'(pw);
            OP_SC1: begin
                fhat_reg <= sat32(64'(fsum_reg));
                dwp_reg  <= sat32(64'(dsum_reg));
                pn2_reg  <= sat32(64'(nsum_reg));
                z1_reg   <= sat32(64'(x1_reg) - 64'(yr_reg));
            end
            OP_ALPHA: begin
                alpha_reg <= sat32(64'(dyr_reg) - 64'(qm) - 64'(fhat_reg));
                dadx_reg  <= sat32(-64'(k1s) - 64'(dwp_reg));
            end
            OP_Z2: begin
                z2_reg <= sat32(64'(x2_reg) - 64'(alpha_reg));
                xf_reg <= sat32(64'(x2_reg) + 64'(fhat_reg));
            end
            OP_TAU: begin
                tau_reg <= sat32(64'(z1_reg) - 64'(qm));
                u_reg   <= 36'(ddyr_reg) - 36'(z1_reg);
            end
            OP_USUB1, OP_USUB2: u_reg <= u_reg - 36'(qm);
            OP_UADD1, OP_UADD2: u_reg <= u_reg + 36'(qm);
            OP_TMP1, OP_TMP2:   tmp_reg <= qm;
            OP_GT: begin
                gt_reg   <= qm;
                udrv_reg <= sat32(64'(u_reg));
                clip_reg <= clip_reg | ovf32(64'(u_reg));
            end
            OP_INC:  tmp_reg  <= sat32(64'(tmp_reg) - 64'(qm));
            OP_WUPD: clip_reg <= clip_reg | ovf32(64'(w_cur) + 64'(qm));
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = drive_reg;
    assign m_tuser  = sat_reg;
endmodule

// ----- src/adaptive_rbf_backstepping_control.sv -----
// top level of the adaptive rbf backstepping controller
//
//  channel  ports                                  word
//  input    s_tvalid s_tready s_tdata[159:0]       position, velocity, ref_value,
//                                                  ref_rate, ref_accel
//  result   m_tvalid m_tready m_tdata[31:0] m_tuser drive, saturated
//  config   cfg_valid cfg_ready cfg_index cfg_data register index and value
//
// one word at a time: a load, then for each basis a distance test; one out of reach
// is zeroed, else a 56-step shift-subtract division gives its ratio and table index,
// and it is zeroed if the index runs off the end or takes a second such division for
// its slope; then the control law and weight update, and the hand-over of the result
// the result sits in an output register, so a new word is taken while it waits;
// the hand-over cycle stalls only while the previous result is still unaccepted
// reset (aresetn low, synchronous) restores the register defaults and weights
// config writes are taken every cycle and are meant for an idle block
module adaptive_rbf_backstepping_control (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // position, velocity, ref_value, ref_rate, ref_accel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // drive
    output logic         m_tuser,   // saturated
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import arbc_pkg::*;

    cmd_t          cmd;
    status_t       status;
    logic [AW-1:0] rom_addr;
    logic [16:0]   rom_data;

    assign cfg_ready = 1'b1;

    arbc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    arbc_exp_rom u_rom (
        .aclk (aclk),
        .addr (rom_addr),
        .data (rom_data)
    );

    arbc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rom_addr  (rom_addr),
        .rom_data  (rom_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );
endmodule

// ----- test/adaptive_rbf_backstepping_control_tb.sv -----
// testbench for the adaptive rbf backstepping controller: directed and random samples checked against a predictor
module adaptive_rbf_backstepping_control_tb;
    import arbc_pkg::*;

    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;
    localparam int STALL_LIMIT = 200000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic         m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [7:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    adaptive_rbf_backstepping_control dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    typedef struct {
        logic [31:0] drive;
        logic        sat;
    } ctrl_out_t;

    ctrl_out_t   pending_q[$];
    longint      exp_tab[EXP_TABLE_DEPTH];
    longint      wts[N_BASIS];
    longint      k1, k2, gam, kw, sig, dt, c0, sp;
    int          send_idle_pct = 0, recv_idle_pct = 0;
    bit          hold_off = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    function automatic longint clip32(longint v, inout bit c);
        if (v > SMAX) begin c = 1; return SMAX; end
        if (v < SMIN) begin c = 1; return SMIN; end
        return v;
    endfunction

    function automatic longint sat(longint v);
        bit d;
        d = 0;
        return clip32(v, d);
    endfunction

    function automatic longint qprod(longint a, longint b);
        longint ua, ub, p;
        bit neg;
        neg = (a < 0) != (b < 0);
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        p = longint'((64'(ua) * 64'(ub)) >> 16);
        return neg ? -p : p;
    endfunction

    function automatic void make_table();
        logic [63:0] xq, term, q;
        longint sum;
        xq = (64'd16 << 30) / 64'(EXP_TABLE_DEPTH);
        term = 64'd1 << 30;
        sum = longint'(term);
        q = 64'd1 << 30;
        for (int n = 1; n <= 14; n++) begin
            term = ((term * xq) >> 30) / 64'(n);
            if (n & 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        if (sum < 0) sum = 0;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            exp_tab[k] = longint'((q + 64'd8192) >> 14);
            q = (q * 64'(sum) + (64'd1 << 29)) >> 30;
        end
    endfunction

    function automatic void reset_model();
        foreach (wts[i]) wts[i] = 655;
        k1 = 65536; k2 = 65536; gam = 65536; kw = 327680;
        sig = 6554; dt = 66; c0 = -131072; sp = 16384;
    endfunction

    function automatic ctrl_out_t control_law(logic [159:0] w);
        longint phi[N_BASIS], dphi[N_BASIS];
        longint x1, x2, yr, dyr, ddyr, s, fs, ds, ns;
        longint fh, dwp, pn2, z1, al, dd, z2, tau, u, gt, inc, diff;
        logic [63:0] ad, r, e, idx, m;
        bit c;
        ctrl_out_t o;
        c = 0; fs = 0; ds = 0; ns = 0;
        x1 = longint'($signed(w[31:0]));
        x2 = longint'($signed(w[63:32]));
        yr = longint'($signed(w[95:64]));
        dyr = longint'($signed(w[127:96]));
        ddyr = longint'($signed(w[159:128]));
        s = sp ? sp : 1;
        for (int i = 0; i < N_BASIS; i++) begin
            diff = x1 - (c0 + i * s);
            ad = diff < 0 ? 64'(-diff) : 64'(diff);
            phi[i] = 0; dphi[i] = 0;
            if (ad < 64'(12 * s)) begin
                r = (ad << 16) / 64'(s);
                e = (r * r) >> 19;
                idx = (e * 64'(EXP_TABLE_DEPTH) + (64'd1 << 19)) >> 20;
                if (idx < 64'(EXP_TABLE_DEPTH)) begin
                    phi[i] = exp_tab[idx];
                    m = (r * 64'(phi[i])) / (64'd4 * 64'(s));
                    if (diff > 0) dphi[i] = m > 64'd2147483648 ? SMIN : -longint'(m);
                    else dphi[i] = m > 64'd2147483647 ? SMAX : longint'(m);
                end
            end
            fs += qprod(wts[i], phi[i]);
            ds += qprod(wts[i], dphi[i]);
            ns += qprod(phi[i], phi[i]);
        end
        fh = sat(fs); dwp = sat(ds); pn2 = sat(ns);
        z1 = sat(x1 - yr);
        al = sat(dyr - sat(qprod(k1, z1)) - fh);
        dd = sat(-k1 - dwp);
        z2 = sat(x2 - al);
        tau = sat(z1 - sat(qprod(z2, dd)));
        u = -sat(qprod(k2, z2)) - z1 + sat(qprod(dd, sat(x2 + fh)))
            + sat(qprod(k1, dyr)) + ddyr - sat(qprod(sat(qprod(kw, z2)), pn2));
        u = clip32(u, c);
        gt = sat(qprod(gam, tau));
        for (int i = 0; i < N_BASIS; i++) begin
            inc = sat(sat(qprod(gt, phi[i])) - sat(qprod(sig, wts[i])));
            wts[i] = clip32(wts[i] + sat(qprod(dt, inc)), c);
        end
        o.drive = u[31:0];
        o.sat = c;
        return o;
    endfunction

    // receiver: random stalls plus an optional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        ctrl_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word drive=%h sat=%b", m_tdata, m_tuser);
            end else begin
                want = pending_q.pop_front();
                if (m_tdata !== want.drive || m_tuser !== want.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch drive exp %h got %h, sat exp %b got %b",
                                 want.drive, m_tdata, want.sat, m_tuser);
                end
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // tvalid stays up after the handshake; the next send reloads or drops it, or the caller drops it
    task automatic send_sample(logic [31:0] x1, x2, yr, dyr, ddyr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ddyr, dyr, yr, x2, x1};
        pending_q.push_back(control_law({ddyr, dyr, yr, x2, x1}));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_GAIN_FIRST:     k1 = val[30:0];
            CFG_GAIN_SECOND:    k2 = val[30:0];
            CFG_ADAPT_RATE:     gam = val[30:0];
            CFG_ROBUST_GAIN:    kw = val[30:0];
            CFG_LEAKAGE:        sig = val[30:0];
            CFG_TIME_STEP:      dt = val[30:0];
            CFG_CENTER_FIRST:   c0 = longint'($signed(val));
            CFG_CENTER_SPACING: sp = val[30:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] near_position();
        longint p;
        p = c0 + longint'($urandom_range(16 * 4)) * ((sp ? sp : 1) / 4)
            - longint'($urandom_range(3)) * sp;
        return 32'(sat(p));
    endfunction

    task automatic test_directed();
        logic [31:0] ext[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        foreach (ext[i]) send_sample(ext[i], ext[3-i], ext[(i+1)%4], ext[(i+2)%4], ext[i]);
        send_sample(32'hFFFE_0000, 0, 0, 0, 0);          // on the first centre
        send_sample(32'h0001_C000, 32'h1_0000, 0, 0, 0); // on the last centre
        send_sample(32'h0003_0000, 0, 0, 0, 0);          // past the last centre, still within reach
        send_sample(32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF);                      // drive clips
        for (int i = 0; i < 8; i++)
            send_sample(near_position(), $urandom(), $urandom_range(65536), 0, 0);
        drain();
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_CENTER_SPACING, 32'h0);   // zero spacing acts as one lsb
        write_reg(CFG_CENTER_FIRST, 32'h8000_0000);
        send_sample(32'h8000_0000, 0, 0, 0, 0);
        send_sample(32'h8000_0008, 1, 2, 3, 4);
        drain();
        write_reg(CFG_CENTER_SPACING, 32'h7FFF_FFFF);
        write_reg(CFG_CENTER_FIRST, 32'h7FFF_FFFF);  // wide centres do not wrap
        write_reg(CFG_GAIN_FIRST, 32'hFFFF_FFFF);
        write_reg(CFG_GAIN_SECOND, 32'h7FFF_FFFF);
        write_reg(CFG_ADAPT_RATE, 32'h7FFF_FFFF);
        write_reg(CFG_ROBUST_GAIN, 32'h7FFF_FFFF);
        write_reg(CFG_LEAKAGE, 32'h7FFF_FFFF);
        write_reg(CFG_TIME_STEP, 32'h7FFF_FFFF);
        write_reg(8'd200, 32'h1234_5678);           // unused index, ignored
        for (int i = 0; i < 6; i++) send_sample($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        drain();
        write_reg(CFG_GAIN_FIRST, 0); write_reg(CFG_GAIN_SECOND, 0);
        write_reg(CFG_ADAPT_RATE, 0); write_reg(CFG_ROBUST_GAIN, 0);
        write_reg(CFG_LEAKAGE, 0); write_reg(CFG_TIME_STEP, 0);
        write_reg(CFG_CENTER_FIRST, 0); write_reg(CFG_CENTER_SPACING, 32'h1_0000);
        for (int i = 0; i < 4; i++) send_sample(near_position(), $urandom(), $urandom(), 0, 0);
        drain();
    endtask

    task automatic random_settings();
        write_reg(CFG_GAIN_FIRST, $urandom_range(4 * 65536));
        write_reg(CFG_GAIN_SECOND, $urandom_range(4 * 65536));
        write_reg(CFG_ADAPT_RATE, $urandom_range(8 * 65536));
        write_reg(CFG_ROBUST_GAIN, $urandom_range(10 * 65536));
        write_reg(CFG_LEAKAGE, $urandom_range(65536));
        write_reg(CFG_TIME_STEP, $urandom_range(20000));
        write_reg(CFG_CENTER_FIRST, $urandom_range(1) ? 32'hFFFE_0000 : $urandom());
        write_reg(CFG_CENTER_SPACING, ($urandom_range(15) == 0) ? $urandom()
                                       : $urandom_range(1 << 18, 1));
    endtask

    task automatic random_sample();
        logic [31:0] x1, yr;
        if ($urandom_range(9) < 8) begin
            x1 = near_position();
            yr = x1 + $urandom_range(131072) - 65536;
            send_sample(x1, $urandom_range(262144) - 131072, yr,
                        $urandom_range(131072) - 65536, $urandom_range(131072) - 65536);
        end else begin
            send_sample($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        end
    endtask

    task automatic test_random(int count);
        for (int ph = 0; ph < 6; ph++) begin
            random_settings();
            for (int i = 0; i < count / 6; i++) random_sample();
            drain();
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1;
                repeat (12000) @(posedge aclk);
                hold_off = 0;
            end
            begin
                for (int i = 0; i < 12; i++) random_sample();
                s_tvalid <= 1'b0;
            end
        join
        drain();   // sender waits for every result
    endtask

    initial begin
        make_table();
        reset_model();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 16; recv_idle_pct = 68;
        test_directed();
        test_config_extremes();
        test_random(580);
        send_idle_pct = 68; recv_idle_pct = 16;
        test_backpressure();
        test_random(580);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(540);
        drain();
        if (mismatches == 0 && pending_q.size() == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
